// ===== design/pks_pkg.sv =====
package pks_pkg;

  localparam int unsigned KnobSlots   = 8;
  localparam int unsigned SampleW     = 10;
  localparam int unsigned LevelW      = 8;
  localparam int unsigned SwitchBits  = 11;
  localparam int unsigned CountW      = 4;
  localparam logic [CountW-1:0] StableScansReset = 4'd8;

  typedef logic [SampleW-1:0]    sample_t;
  typedef logic [LevelW-1:0]     level_t;
  typedef logic [SwitchBits-1:0] switch_word_t;
  typedef logic [CountW-1:0]     count_t;

  typedef struct packed {
    sample_t      knob_sample_0;
    sample_t      knob_sample_1;
    sample_t      knob_sample_2;
    sample_t      knob_sample_3;
    sample_t      knob_sample_4;
    sample_t      knob_sample_5;
    sample_t      knob_sample_6;
    sample_t      knob_sample_7;
    switch_word_t raw_switches;
  } scan_t;

  typedef struct packed {
    level_t       knob_value_0;
    level_t       knob_value_1;
    level_t       knob_value_2;
    level_t       knob_value_3;
    level_t       knob_value_4;
    level_t       knob_value_5;
    level_t       knob_value_6;
    level_t       knob_value_7;
    logic [KnobSlots-1:0] knob_changed;
    switch_word_t switch_pressed;
    switch_word_t switch_released;
  } result_t;

  // Moves level by floor((target - level) / 4).
  function automatic level_t smooth_knob(level_t level, level_t target);
    logic signed [LevelW:0] diff;
    logic signed [LevelW:0] sum;
    diff = $signed({1'b0, target}) - $signed({1'b0, level});
    sum  = $signed({1'b0, level}) + (diff >>> 2);
    return sum[LevelW-1:0];
  endfunction

endpackage

// ===== design/pks_stream_if.sv =====
interface pks_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/panel_knob_smoother_switch_debouncer.sv =====
// Panel knob smoother and switch debouncer.
// scan_i   : one request per panel scan, eight 10-bit knob samples plus an
//            active-low switch word (pks_pkg::scan_t).
// result_o : one result per scan, smoothed 8-bit knob values, knob changed
//            flags, and one-shot pressed/released switch events
//            (pks_pkg::result_t).
// cfg_i    : 4-bit stable_scans write, always ready; write only while idle.
// A scan taken by scan_i shows on result_o in the cycle after it is taken.
// Throughput is one scan per cycle unless the receiver stalls; the knob and
// switch state update in the same cycle the scan is taken, and a single
// result register holds the output. scan_i.ready is low only while that
// register is full and result_o.ready is low, so a stalled receiver holds
// the pending result and back-pressures the scan side without losing state.
// Reset clears knob levels to zero, all switches to released with zero
// counters, empties the result register and sets stable_scans to 8.
module panel_knob_smoother_switch_debouncer #(
  parameter int unsigned SWITCH_COUNT = 11,
  parameter int unsigned KNOB_COUNT   = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pks_stream_if.sink    scan_i,
  pks_stream_if.source  result_o,
  pks_stream_if.sink    cfg_i
);

  localparam int unsigned KnobSlots  = pks_pkg::KnobSlots;
  localparam int unsigned SwitchBits = pks_pkg::SwitchBits;

  pks_pkg::count_t  stable_scans_q;
  pks_pkg::result_t res_q;
  pks_pkg::result_t res_d;
  logic             res_valid_q;
  logic             scan_accept;

  pks_pkg::sample_t sample [KnobSlots];
  pks_pkg::level_t  knob_value [KnobSlots];
  logic [KnobSlots-1:0]    knob_changed;
  logic [SWITCH_COUNT-1:0] pressed_all;
  logic [SWITCH_COUNT-1:0] released_all;
  pks_pkg::switch_word_t   pressed;
  pks_pkg::switch_word_t   released;

  assign scan_i.ready   = !res_valid_q || result_o.ready;
  assign scan_accept    = scan_i.valid && scan_i.ready;
  assign cfg_i.ready    = 1'b1;
  assign result_o.valid  = res_valid_q;
  assign result_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_scans_q <= pks_pkg::StableScansReset;
    end else if (cfg_i.valid) begin
      stable_scans_q <= cfg_i.payload;
    end
  end

  always_comb begin
    sample[0] = scan_i.payload.knob_sample_0;
    sample[1] = scan_i.payload.knob_sample_1;
    sample[2] = scan_i.payload.knob_sample_2;
    sample[3] = scan_i.payload.knob_sample_3;
    sample[4] = scan_i.payload.knob_sample_4;
    sample[5] = scan_i.payload.knob_sample_5;
    sample[6] = scan_i.payload.knob_sample_6;
    sample[7] = scan_i.payload.knob_sample_7;
  end

  for (genvar k = 0; k < KnobSlots; k++) begin : g_knob
    if (k < KNOB_COUNT) begin : g_used
      pks_pkg::level_t level_q;
      pks_pkg::level_t level_d;

      assign level_d = pks_pkg::smooth_knob(level_q,
                         sample[k][pks_pkg::SampleW-1 -: pks_pkg::LevelW]);
      assign knob_value[k]   = level_d;
      assign knob_changed[k] = (level_d != level_q);

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          level_q <= '0;
        end else if (scan_accept) begin
          level_q <= level_d;
        end
      end
    end else begin : g_unused
      assign knob_value[k]   = '0;
      assign knob_changed[k] = 1'b0;
    end
  end

  for (genvar i = 0; i < SWITCH_COUNT; i++) begin : g_switch
    logic            now;
    logic            level_q;
    pks_pkg::count_t count_q;
    pks_pkg::count_t count_inc;
    pks_pkg::count_t count_d;
    logic            fire;

    if (i < SwitchBits) begin : g_pin
      assign now = !scan_i.payload.raw_switches[i];
    end else begin : g_nopin
      assign now = 1'b1;
    end

    assign count_inc = count_q + pks_pkg::count_t'(1);

    always_comb begin
      count_d = count_q;
      fire    = 1'b0;
      priority if (now != level_q) begin
        count_d = '0;
      end else if (count_q < stable_scans_q) begin
        count_d = count_inc;
        fire    = (count_inc == stable_scans_q);
      end
    end

    assign pressed_all[i]  = fire && now;
    assign released_all[i] = fire && !now;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        level_q <= 1'b0;
        count_q <= '0;
      end else if (scan_accept) begin
        level_q <= now;
        count_q <= count_d;
      end
    end
  end

  for (genvar j = 0; j < SwitchBits; j++) begin : g_event
    if (j < SWITCH_COUNT) begin : g_map
      assign pressed[j]  = pressed_all[j];
      assign released[j] = released_all[j];
    end else begin : g_zero
      assign pressed[j]  = 1'b0;
      assign released[j] = 1'b0;
    end
  end

  always_comb begin
    res_d.knob_value_0    = knob_value[0];
    res_d.knob_value_1    = knob_value[1];
    res_d.knob_value_2    = knob_value[2];
    res_d.knob_value_3    = knob_value[3];
    res_d.knob_value_4    = knob_value[4];
    res_d.knob_value_5    = knob_value[5];
    res_d.knob_value_6    = knob_value[6];
    res_d.knob_value_7    = knob_value[7];
    res_d.knob_changed    = knob_changed;
    res_d.switch_pressed  = pressed;
    res_d.switch_released = released;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (scan_accept) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_accept) begin
      res_q <= res_d;
    end
  end

endmodule
